// File: hdl/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Types and constants shared by the command frame builder modules.
// ----------------------------------------------------------------------------
package scpf_pkg;

  // fixed header bytes
  localparam logic [7:0] HDR_BYTE0 = 8'hEF;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;

  // module address after reset
  localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

  // length field adds the two checksum bytes
  localparam logic [15:0] LEN_EXTRA = 16'd2;

  // byte positions inside a frame
  localparam int unsigned STEP_W = 4;
  typedef enum logic [STEP_W-1:0] {
    STEP_HDR0   = 4'd0,
    STEP_HDR1   = 4'd1,
    STEP_ADDR3  = 4'd2,
    STEP_ADDR2  = 4'd3,
    STEP_ADDR1  = 4'd4,
    STEP_ADDR0  = 4'd5,
    STEP_TYPE   = 4'd6,
    STEP_LEN_HI = 4'd7,
    STEP_LEN_LO = 4'd8,
    STEP_DATA   = 4'd9,
    STEP_SUM_HI = 4'd10,
    STEP_SUM_LO = 4'd11
  } step_t;

  // one classified word handed from the front to the back
  typedef struct packed {
    logic        is_open;   // word opens a frame, header goes first
    logic        has_data;  // a payload byte goes out
    logic        is_last;   // checksum closes the frame after this word
    logic [31:0] addr;
    logic [7:0]  ptype;
    logic [15:0] flen;
    logic [7:0]  data;
    logic [15:0] sum;
  } entry_t;

endpackage

// File: hdl/scpf_front.sv
// ----------------------------------------------------------------------------
// scpf_front
// Accepts input words, tracks the open frame and classifies each word.
// ----------------------------------------------------------------------------
module scpf_front
  import scpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // input word
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ptype,
  input  logic [15:0] in_plen,
  input  logic [7:0]  in_data,
  // to queue
  output logic        push_valid,
  input  logic        push_ready,
  output entry_t      push_entry
);

  logic [31:0] addr_r;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] flen;
  logic [15:0] sum_open;
  logic [15:0] sum_e;
  logic        accept;

  assign cfg_ready  = 1'b1;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // classify the word against the open frame
  always_comb begin
    flen     = in_plen + LEN_EXTRA;
    sum_open = {8'd0, in_ptype} + {8'd0, flen[15:8]} + {8'd0, flen[7:0]};
    push_entry       = '0;
    push_entry.addr  = addr_r;
    push_entry.ptype = in_ptype;
    push_entry.flen  = flen;
    push_entry.data  = in_data;
    if (rem_r == 16'd0) begin
      push_entry.is_open  = 1'b1;
      push_entry.has_data = (in_plen != 16'd0);
      push_entry.is_last  = (in_plen <= 16'd1);
      sum_e   = (in_plen == 16'd0) ? sum_open : sum_open + {8'd0, in_data};
      rem_nxt = (in_plen == 16'd0) ? 16'd0 : in_plen - 16'd1;
    end else begin
      push_entry.is_open  = 1'b0;
      push_entry.has_data = 1'b1;
      push_entry.is_last  = (rem_r == 16'd1);
      sum_e   = sum_r + {8'd0, in_data};
      rem_nxt = rem_r - 16'd1;
    end
    push_entry.sum = sum_e;
    sum_nxt = push_entry.is_last ? 16'd0 : sum_e;
  end

  // frame tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 16'd0;
      sum_r <= 16'd0;
    end else if (accept) begin
      rem_r <= rem_nxt;
      sum_r <= sum_nxt;
    end
  end

  // module address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else if (cfg_valid) begin
      addr_r <= cfg_data;
    end
  end

endmodule

// File: hdl/scpf_queue.sv
// ----------------------------------------------------------------------------
// scpf_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module scpf_queue
  import scpf_pkg::*;
#(
  parameter int unsigned DEPTH = 2
)
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   head_valid,
  input  logic   pop,
  output entry_t head_entry
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;

  assign push_ready = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // fill count stays within the queue
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  // the back never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // a lone pop lowers the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count not reduced by pop");
`endif

endmodule

// File: hdl/scpf_back.sv
// ----------------------------------------------------------------------------
// scpf_back
// Expands each classified word into frame bytes through an output register.
// ----------------------------------------------------------------------------
module scpf_back
  import scpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end
);

  logic       started_r, started_nxt;
  step_t      step_r, step_nxt;
  step_t      cur;
  logic       load;
  logic       word_done;
  logic [7:0] byte_sel;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r;

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_end   = end_r;

  // position of the next byte of the head word
  assign cur  = started_r ? step_r : (head_entry.is_open ? STEP_HDR0 : STEP_DATA);
  assign load = head_valid && (!valid_r || out_ready);
  assign word_done = (cur == STEP_SUM_LO) || ((cur == STEP_DATA) && !head_entry.is_last);
  assign pop  = load && word_done;

  // byte select
  always_comb begin
    unique case (cur)
      STEP_HDR0:   byte_sel = HDR_BYTE0;
      STEP_HDR1:   byte_sel = HDR_BYTE1;
      STEP_ADDR3:  byte_sel = head_entry.addr[31:24];
      STEP_ADDR2:  byte_sel = head_entry.addr[23:16];
      STEP_ADDR1:  byte_sel = head_entry.addr[15:8];
      STEP_ADDR0:  byte_sel = head_entry.addr[7:0];
      STEP_TYPE:   byte_sel = head_entry.ptype;
      STEP_LEN_HI: byte_sel = head_entry.flen[15:8];
      STEP_LEN_LO: byte_sel = head_entry.flen[7:0];
      STEP_DATA:   byte_sel = head_entry.data;
      STEP_SUM_HI: byte_sel = head_entry.sum[15:8];
      STEP_SUM_LO: byte_sel = head_entry.sum[7:0];
      default:     byte_sel = 8'd0;
    endcase
  end

  // step sequencing, payload is skipped on an empty frame
  always_comb begin
    started_nxt = started_r;
    step_nxt    = step_r;
    if (load) begin
      if (word_done) begin
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        step_nxt    = ((cur == STEP_LEN_LO) && !head_entry.has_data) ?
                      STEP_SUM_HI : step_t'(cur + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      step_r    <= STEP_HDR0;
    end else begin
      started_r <= started_nxt;
      step_r    <= step_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_sel;
      end_r  <= (cur == STEP_SUM_LO);
    end
  end

`ifndef SYNTHESIS
  // the frame end flag comes with popping a closing word
  a_end_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (cur == STEP_SUM_LO)) |-> (pop && head_entry.is_last))
    else $error("frame end without closing word");

  // a word in progress keeps its position while the output stalls
  a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!load) |=> ($stable(step_r) && $stable(started_r)))
    else $error("step moved without a load");

  // the sequencer never runs past the low checksum byte
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (step_r <= STEP_SUM_LO))
    else $error("step beyond frame end");
`endif

endmodule

// File: hdl/sensor_command_packet_framer.sv
// ----------------------------------------------------------------------------
// sensor_command_packet_framer
// Builds fingerprint module command frames from a stream of payload words.
// ----------------------------------------------------------------------------
// The input side takes one word per cycle while the internal queue has room.
// A word that opens a frame yields nine header bytes (0xEF, 0x01, four address
// bytes, type, length high and low), then its payload byte if the length is
// nonzero; the word that closes a frame adds two checksum bytes, the low one
// flagged by out_tlast. Payload inside a frame leaves at one byte per cycle
// while out_tready is high and words are queued, as the byte sequencer of the
// back end emits one byte per cycle under that condition. The module address
// is sampled into each word as it is accepted.
module sensor_command_packet_framer
  import scpf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2  // 2 to 16 words
)
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,       // module_address
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,       // packet_type[7:0], payload_length[23:8],
                                      // data_byte[31:24]
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,      // frame_byte[7:0]
  output logic        out_tlast
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   head_valid, pop;
  entry_t head_entry;

  // front: accept and classify
  scpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_ptype   (in_tdata[7:0]),
    .in_plen    (in_tdata[23:8]),
    .in_data    (in_tdata[31:24]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // queue between front and back
  scpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head_entry (head_entry)
  );

  // back: byte sequencer and output register
  scpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_end    (out_tlast)
  );

endmodule

// File: test/scpf_frame_checker.sv
// ----------------------------------------------------------------------------
// scpf_frame_checker
// Watches the configuration, input and output channels of the command frame
// builder, works out the frame bytes each accepted input word must produce
// and compares every output byte against the oldest byte still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scpf_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // packet_type[7:0], payload_length[23:8],
                                   // data_byte[31:24]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,   // frame_byte[7:0]
  input  logic        out_tlast,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned bytes_checked
);

  localparam logic [7:0]  SYNC_HI      = 8'hEF;
  localparam logic [7:0]  SYNC_LO      = 8'h01;
  localparam logic [31:0] ADDR_DEFAULT = 32'hFFFF_FFFF;
  localparam int unsigned PRINT_LIMIT  = 30;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  frame_byte_t bytes_due[$];
  logic [31:0] frame_addr;
  logic [15:0] payload_left;
  logic [15:0] frame_sum;

  initial begin
    fail_count    = 0;
    pending       = 0;
    bytes_checked = 0;
    frame_addr    = ADDR_DEFAULT;
    payload_left  = '0;
    frame_sum     = '0;
  end

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    if (fail_count < PRINT_LIMIT)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  function automatic void owe_byte(logic [7:0] value, logic last);
    frame_byte_t b;
    b.value = value;
    b.last  = last;
    bytes_due.push_back(b);
  endfunction

  // checksum high then low, the low byte ends the frame
  function automatic void owe_checksum();
    owe_byte(frame_sum[15:8], 1'b0);
    owe_byte(frame_sum[7:0], 1'b1);
    frame_sum = '0;
  endfunction

  function automatic void owe_payload(logic [7:0] d);
    owe_byte(d, 1'b0);
    frame_sum    = frame_sum + 16'(d);
    payload_left = payload_left - 16'd1;
    if (payload_left == 16'd0)
      owe_checksum();
  endfunction

  // bytes one accepted input word must produce
  function automatic void predict_frame_bytes(logic [31:0] word);
    logic [7:0]  ptype;
    logic [15:0] plen;
    logic [15:0] flen;
    logic [7:0]  d;
    ptype = word[7:0];
    plen  = word[23:8];
    d     = word[31:24];
    if (payload_left != 16'd0) begin
      owe_payload(d);
    end else begin
      // length field counts the checksum too and wraps at 16 bits
      flen = plen + 16'd2;
      owe_byte(SYNC_HI, 1'b0);
      owe_byte(SYNC_LO, 1'b0);
      owe_byte(frame_addr[31:24], 1'b0);
      owe_byte(frame_addr[23:16], 1'b0);
      owe_byte(frame_addr[15:8], 1'b0);
      owe_byte(frame_addr[7:0], 1'b0);
      owe_byte(ptype, 1'b0);
      owe_byte(flen[15:8], 1'b0);
      owe_byte(flen[7:0], 1'b0);
      frame_sum    = 16'(ptype) + 16'(flen[15:8]) + 16'(flen[7:0]);
      payload_left = plen;
      if (plen == 16'd0)
        owe_checksum();
      else
        owe_payload(d);
    end
  endfunction

  // input words are predicted before the output byte of the same edge is checked
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      frame_addr   = ADDR_DEFAULT;
      payload_left = '0;
      frame_sum    = '0;
      bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        frame_addr = cfg_data;
      if (in_tvalid && in_tready)
        predict_frame_bytes(in_tdata);
      if (out_tvalid && out_tready) begin
        if (bytes_due.size() == 0) begin
          report_mismatch("frame byte with nothing owed", 0, out_tdata);
        end else begin
          want = bytes_due.pop_front();
          if (out_tdata !== want.value)
            report_mismatch("frame_byte", want.value, out_tdata);
          if (out_tlast !== want.last)
            report_mismatch("frame_end", want.last, out_tlast);
          bytes_checked++;
        end
      end
    end
    pending = bytes_due.size();
  end

endmodule

// File: test/sensor_command_packet_framer_tb.sv
// ----------------------------------------------------------------------------
// sensor_command_packet_framer_tb
// Drives payload words and module address writes into the frame builder and
// lets the frame checker compare every output byte. Covers empty and one-byte
// frames, a wrapping length field, random frames under random stalls and a
// long output back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sensor_command_packet_framer_tb;

  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned HOLD_AFTER   = 200;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned WRAP_WORDS   = 8;
  localparam int          FILL_RANDOM  = -1;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;       // module_address
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;       // packet_type[7:0], payload_length[23:8],
                               // data_byte[31:24]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;      // frame_byte[7:0]
  logic        out_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_checked;
  int unsigned words_sent;
  int unsigned frames_sent;
  int unsigned addr_writes;
  bit          calm;           // no idling on either side while set

  initial clk = 1'b0;
  always #4 clk = ~clk;

  sensor_command_packet_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  scpf_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  // one input word, called and returning at a falling edge
  task automatic send_word(logic [7:0] ptype, logic [15:0] plen, logic [7:0] d);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, plen, ptype};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // opening word then the rest of the payload, with noise in the unused fields
  task automatic send_frame(logic [7:0] ptype, logic [15:0] plen, int fill);
    int unsigned n;
    logic [7:0]  d;
    n = (plen == 16'd0) ? 1 : plen;
    for (int unsigned i = 0; i < n; i++) begin
      d = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      if (i == 0)
        send_word(ptype, plen, d);
      else
        send_word(8'($urandom_range(0, 255)), 16'($urandom), d);
    end
    frames_sent++;
  endtask

  // address write once every owed byte has left the block
  task automatic write_address(logic [31:0] value);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    addr_writes++;
  endtask

  // receiver: random stalls, one long hold once the block is busy
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          held;
    taken      = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held && taken == HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  // watchdog on cycles where no word moves on any channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no word moved for %0d cycles, %0d frame bytes still owed", quiet, pending);
    $display("simulation failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned random_start;
    logic [15:0] plen;
    logic [31:0] addr;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    calm        = 1'b0;
    words_sent  = 0;
    frames_sent = 0;
    addr_writes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset address, empty and one-byte frames, all-ones payload
    send_frame(8'h00, 16'd0, FILL_RANDOM);
    send_frame(8'hFF, 16'd0, FILL_RANDOM);
    send_frame(8'h5A, 16'd1, 8'h00);
    send_frame(8'hFF, 16'd1, 8'hFF);
    send_frame(8'h30, 16'd4, 8'hFF);
    write_address(32'h0000_0000);
    calm = 1'b1;
    send_frame(8'h01, 16'd2, FILL_RANDOM);
    calm = 1'b0;
    send_frame(8'hA5, 16'd0, FILL_RANDOM);
    write_address(32'hA5C3_0F96);
    send_frame(8'h07, 16'd3, 8'h80);

    // random frames, mostly short, address changed every few frames
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      if (frames_sent % 8 == 0) begin
        case ($urandom_range(0, 3))
          0:       addr = 32'h0000_0000;
          1:       addr = 32'hFFFF_FFFF;
          default: addr = $urandom;
        endcase
        write_address(addr);
      end
      calm = ($urandom_range(0, 4) == 0);
      plen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 60))
                                         : 16'($urandom_range(0, 12));
      send_frame(8'($urandom_range(0, 255)), plen, FILL_RANDOM);
    end

    // length whose length field wraps, frame left open after a few payload words
    write_address($urandom);
    calm = 1'b1;
    send_word(8'($urandom_range(0, 255)), 16'hFFFF, 8'($urandom_range(0, 255)));
    for (int unsigned i = 0; i < WRAP_WORDS; i++)
      send_word(8'($urandom_range(0, 255)), 16'($urandom), 8'($urandom_range(0, 255)));
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d frames in %0d input words under %0d address writes",
             frames_sent, words_sent, addr_writes);
    $display("checked %0d frame bytes, a wrapping length and a long output hold included",
             bytes_checked);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sensor_command_packet_framer.f
hdl/scpf_pkg.sv
hdl/scpf_front.sv
hdl/scpf_queue.sv
hdl/scpf_back.sv
hdl/sensor_command_packet_framer.sv
test/scpf_frame_checker.sv
test/sensor_command_packet_framer_tb.sv
